/* rtl/esd_pkg.sv */
// Shared types and constants for the escape sequence decoder.
// Depends on nothing; every other file imports it.
`timescale 1ns / 1ps
`default_nettype none

package esd_pkg;

	// One raw character of a string literal
	typedef struct packed {
		logic [7:0] char_in;
		logic       final_char;
	} in_item_t;

	// One decoded byte
	typedef struct packed {
		logic [7:0] byte_out;
		logic       run_end;
		logic       literal_end;
	} out_item_t;

	// Decoder mode
	typedef enum logic [1:0] {
		MODE_PLAIN = 2'd0,
		MODE_ESC   = 2'd1,
		MODE_HEX0  = 2'd2,
		MODE_HEX1  = 2'd3
	} mode_t;

	// Result of decoding one character: up to two bytes and the next state
	typedef struct packed {
		logic [1:0] n;
		out_item_t  res0;
		out_item_t  res1;
		mode_t      next_mode;
		logic [3:0] next_nibble;
	} dec_t;

	localparam logic [7:0] CH_BACKSLASH = 8'h5C;
	localparam logic [7:0] CH_X         = 8'h78;
	localparam logic [7:0] CH_N         = 8'h6E;
	localparam logic [7:0] CH_T         = 8'h74;
	localparam logic [7:0] CH_R         = 8'h72;
	localparam logic [7:0] CH_ZERO      = 8'h30;
	localparam logic [7:0] BYTE_LF      = 8'h0A;
	localparam logic [7:0] BYTE_TAB     = 8'h09;
	localparam logic [7:0] BYTE_CR      = 8'h0D;
	localparam logic [7:0] BYTE_NUL     = 8'h00;

	// Output queue sizing
	localparam int OUT_DEPTH = 4;
	localparam int PTR_W     = $clog2(OUT_DEPTH);
	localparam int CNT_W     = $clog2(OUT_DEPTH + 1);

endpackage

`default_nettype wire

/* rtl/esd_decode.sv */
// Combinational decode of one literal character against the current mode.
// Depends on esd_pkg for item, mode and result types.
`timescale 1ns / 1ps
`default_nettype none

module esd_decode import esd_pkg::*; (
	input  mode_t      mode,
	input  logic [3:0] nibble,
	input  in_item_t   item,
	output dec_t       dec
);

	// Hex digit value, top bit set when the character is a hex digit
	function automatic logic [4:0] hex_value(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, 4'(c - 8'h30)};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			r = {1'b1, 4'(c - 8'h57)};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r = {1'b1, 4'(c - 8'h37)};
		end
		return r;
	endfunction

	logic [7:0] c;
	logic       fin;
	logic [4:0] hex;
	logic       plain_esc;
	logic [7:0] b0;
	logic [7:0] b1;
	logic [1:0] n;
	mode_t      nmode;
	logic [3:0] nnib;

	assign c         = item.char_in;
	assign fin       = item.final_char;
	assign hex       = hex_value(c);
	assign plain_esc = (c == CH_BACKSLASH) && !fin;

	// Select emitted bytes and next state per mode
	always_comb begin
		b0    = c;
		b1    = c;
		n     = 2'd0;
		nmode = MODE_PLAIN;
		nnib  = nibble;
		unique case (mode)
			MODE_PLAIN: begin
				if (plain_esc) begin
					nmode = MODE_ESC;
				end else begin
					n = 2'd1;
				end
			end
			MODE_ESC: begin
				n = 2'd1;
				if (c == CH_N) begin
					b0 = BYTE_LF;
				end else if (c == CH_T) begin
					b0 = BYTE_TAB;
				end else if (c == CH_R) begin
					b0 = BYTE_CR;
				end else if (c == CH_ZERO) begin
					b0 = BYTE_NUL;
				end else if (c == CH_X && !fin) begin
					n     = 2'd0;
					nmode = MODE_HEX0;
				end
			end
			MODE_HEX0: begin
				if (hex[4]) begin
					if (fin) begin
						n  = 2'd1;
						b0 = {4'd0, hex[3:0]};
					end else begin
						nnib  = hex[3:0];
						nmode = MODE_HEX1;
					end
				end else begin
					// lone x, then the character as plain text or as the start of a new escape
					b0 = CH_X;
					if (plain_esc) begin
						n     = 2'd1;
						nmode = MODE_ESC;
					end else begin
						n = 2'd2;
					end
				end
			end
			MODE_HEX1: begin
				nnib = 4'd0;
				if (hex[4]) begin
					n  = 2'd1;
					b0 = {nibble, hex[3:0]};
				end else begin
					// one-digit byte, then the character as plain text or as the start of a new escape
					b0 = {4'd0, nibble};
					if (plain_esc) begin
						n     = 2'd1;
						nmode = MODE_ESC;
					end else begin
						n = 2'd2;
					end
				end
			end
			default: begin
				n = 2'd0;
			end
		endcase
		if (fin) begin
			nmode = MODE_PLAIN;
			nnib  = 4'd0;
		end
	end

	// Pack results, marking the last one
	always_comb begin
		dec.n                 = n;
		dec.next_mode         = nmode;
		dec.next_nibble       = nnib;
		dec.res0.byte_out     = b0;
		dec.res0.run_end      = (n == 2'd1);
		dec.res0.literal_end  = (n == 2'd1) && fin;
		dec.res1.byte_out     = b1;
		dec.res1.run_end      = 1'b1;
		dec.res1.literal_end  = fin;
	end

endmodule

`default_nettype wire

/* rtl/escape_sequence_decoder_top.sv */
// Top level of the escape sequence decoder: mode registers and output queue.
// Depends on esd_pkg and esd_decode.
//
// Usage:
//   Characters of a string literal enter on the char channel (valid/ready),
//   one per transfer, final_char set on the last one. Decoded bytes leave on
//   the byte channel (valid/ready), with run_end on the last byte caused by a
//   character and literal_end on the final byte of the literal.
//   Each accepted character is decoded in the cycle of its transfer against
//   the mode registers; its zero, one or two bytes are written to a
//   four-entry output queue. The first byte is offered in the next cycle
//   if the queue was empty. The block accepts one character per cycle while the
//   queue has two free entries; bytes leave at one per cycle while byte_ready
//   is high, so characters that produce two bytes drain at the byte rate.
//   When the receiver stalls, the queue fills and char_ready drops once
//   fewer than two entries are free; nothing is lost.
//   Reset clears the mode to plain text, the held hex digit and the queue.
`timescale 1ns / 1ps
`default_nettype none

module escape_sequence_decoder_top import esd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      char_valid,
	output logic      char_ready,
	input  in_item_t  char_item,
	output logic      byte_valid,
	input  logic      byte_ready,
	output out_item_t byte_item
);

	mode_t              mode_q;
	logic [3:0]         nibble_q;
	dec_t               dec;
	out_item_t          queue_q [OUT_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               char_xfer;
	logic               byte_xfer;

	esd_decode u_decode (
		.mode   (mode_q),
		.nibble (nibble_q),
		.item   (char_item),
		.dec    (dec)
	);

	assign char_ready = (count_q <= CNT_W'(OUT_DEPTH - 2));
	assign char_xfer  = char_valid && char_ready;
	assign byte_valid = (count_q != '0);
	assign byte_xfer  = byte_valid && byte_ready;
	assign byte_item  = queue_q[rd_ptr_q];

	// Advance decoder mode on each character transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_PLAIN;
			nibble_q <= 4'd0;
		end else if (char_xfer) begin
			mode_q   <= dec.next_mode;
			nibble_q <= dec.next_nibble;
		end
	end

	// Write decoded bytes into the queue
	always_ff @(posedge clk) begin
		if (char_xfer && dec.n != 2'd0) begin
			queue_q[wr_ptr_q] <= dec.res0;
		end
		if (char_xfer && dec.n == 2'd2) begin
			queue_q[wr_ptr_q + PTR_W'(1)] <= dec.res1;
		end
	end

	// Track queue pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (char_xfer) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(dec.n);
			end
			if (byte_xfer) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			count_q <= count_q + (char_xfer ? CNT_W'(dec.n) : CNT_W'(0))
				- (byte_xfer ? CNT_W'(1) : CNT_W'(0));
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(OUT_DEPTH))
		else $error("output queue overfilled");

	a_final_plain: assert property (@(posedge clk) disable iff (!arst_n)
		(char_xfer && char_item.final_char) |=> (mode_q == MODE_PLAIN))
		else $error("mode not plain after final character");

	a_silent_escape: assert property (@(posedge clk) disable iff (!arst_n)
		(char_xfer && dec.n == 2'd0) |=>
		(mode_q == MODE_ESC || mode_q == MODE_HEX0 || mode_q == MODE_HEX1))
		else $error("character without result left decoder outside an escape");

	a_nibble_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q != MODE_HEX1) |-> (nibble_q == 4'd0))
		else $error("held hex digit outside hex escape");
`endif

endmodule

`default_nettype wire
